### rtl/hnc_pkg.sv
package hnc_pkg;

	// field widths
	localparam int unsigned HGT_W   = 8;
	localparam int unsigned COL_W   = 8;
	localparam int unsigned NRM_W   = 16;
	localparam int unsigned IN_W    = 5 * HGT_W;
	localparam int unsigned OUT_W   = HGT_W + 3 * COL_W + 3 * NRM_W;

	// configuration port
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 8;
	localparam logic [CFG_IDX_W-1:0] REG_WATER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNOW  = 2'd2;
	localparam logic [CFG_W-1:0] WATER_RST = 8'd120;
	localparam logic [CFG_W-1:0] SAND_RST  = 8'd125;
	localparam logic [CFG_W-1:0] SNOW_RST  = 8'd200;

	// normal datapath widths
	localparam int unsigned MAG_W  = 9;   // |vx|, |vy| <= 510
	localparam int unsigned SQ_W   = 18;  // squares <= 260100
	localparam int unsigned SUM_W  = 20;  // sum of squares <= 520216
	localparam int unsigned QUO_W  = 31;  // c^2 * 2^30 / S <= 2^30
	localparam int unsigned RAD_W  = 32;  // radicand padded to even width
	localparam int unsigned ROOT_W = 16;
	localparam int unsigned SREM_W = 17;
	localparam logic [SQ_W-1:0] Z_SQ = 18'd16;          // vz = 4
	localparam logic signed [NRM_W-1:0] Q_ONE = 16'sd16384;

	localparam int unsigned FIFO_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		TER_GRASS,
		TER_SAND,
		TER_SNOW,
		TER_WATER
	} terrain_t;

	// classified item passed from front to back
	typedef struct packed {
		logic [HGT_W-1:0] height;
		terrain_t         kind;
		logic [MAG_W-1:0] mag_x;
		logic             neg_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_y;
	} vec_item_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} rgb_t;

	function automatic rgb_t terrain_color(terrain_t kind);
		rgb_t c;
		unique case (kind)
			TER_WATER: c = '{red: 8'd0,   green: 8'd84,  blue: 8'd148};
			TER_SAND:  c = '{red: 8'd248, green: 8'd214, blue: 8'd114};
			TER_SNOW:  c = '{red: 8'd255, green: 8'd250, blue: 8'd250};
			TER_GRASS: c = '{red: 8'd0,   green: 8'd154, blue: 8'd22};
			default:   c = '{red: 8'd0,   green: 8'd154, blue: 8'd22};
		endcase
		return c;
	endfunction

endpackage

### rtl/hnc_front.sv
module hnc_front import hnc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [IN_W-1:0]      in_data,
	output vec_item_t            item
);

	logic [CFG_W-1:0] water_q, sand_q, snow_q;
	logic [HGT_W-1:0] h, hl, hr, hu, hd;
	logic signed [HGT_W+2:0] p, q, vx, vy;
	terrain_t kind;

	// level registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_q <= WATER_RST;
			sand_q  <= SAND_RST;
			snow_q  <= SNOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WATER: water_q <= cfg_data;
				REG_SAND:  sand_q  <= cfg_data;
				REG_SNOW:  snow_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	assign h  = in_data[HGT_W-1:0];
	assign hl = in_data[2*HGT_W-1:HGT_W];
	assign hr = in_data[3*HGT_W-1:2*HGT_W];
	assign hu = in_data[4*HGT_W-1:3*HGT_W];
	assign hd = in_data[5*HGT_W-1:4*HGT_W];

	// slope vector (q - p, -(p + q), 4)
	always_comb begin
		p  = $signed({3'b000, hl}) - $signed({3'b000, hr});
		q  = $signed({3'b000, hu}) - $signed({3'b000, hd});
		vx = q - p;
		vy = -(p + q);
	end

	// terrain class: water wins, then snow, then sand
	always_comb begin
		priority if (h <= water_q) kind = TER_WATER;
		else if (h >= snow_q)      kind = TER_SNOW;
		else if (h <= sand_q)      kind = TER_SAND;
		else                       kind = TER_GRASS;
	end

	always_comb begin
		item.height = h;
		item.kind   = kind;
		item.neg_x  = vx[HGT_W+2];
		item.neg_y  = vy[HGT_W+2];
		item.mag_x  = vx[HGT_W+2] ? MAG_W'(-vx) : MAG_W'(vx);
		item.mag_y  = vy[HGT_W+2] ? MAG_W'(-vy) : MAG_W'(vy);
	end

endmodule

### rtl/hnc_fifo.sv
module hnc_fifo import hnc_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF,
	parameter int unsigned WIDTH = $bits(vec_item_t)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/hnc_back.sv
module hnc_back import hnc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  vec_item_t        item,
	output logic             item_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	localparam int unsigned LANES = 3;
	localparam int unsigned DIV_N = QUO_W;
	localparam int unsigned SQ_N  = RAD_W / 2;
	localparam int unsigned NPOS  = 3 + DIV_N + SQ_N;

	typedef struct packed {
		logic [HGT_W-1:0] height;
		terrain_t         kind;
		logic             neg_x;
		logic             neg_y;
	} side_t;

	logic en;
	side_t side_s [NPOS];
	logic  vld_s  [NPOS];

	logic [MAG_W-1:0] mx_s1, my_s1;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [SUM_W-1:0] sum_s3;
	logic [SUM_W-1:0] csq_s3 [LANES];

	logic [SUM_W-1:0] dsum_s [DIV_N];
	logic [SUM_W-1:0] drem_s [LANES][DIV_N];
	logic [QUO_W-1:0] dquo_s [LANES][DIV_N];

	logic [RAD_W-1:0]  rad_s  [LANES][SQ_N];
	logic [SREM_W-1:0] srem_s [LANES][SQ_N];
	logic [ROOT_W-1:0] root_s [LANES][SQ_N];

	logic m_valid_q;
	logic [HGT_W-1:0] height_q;
	terrain_t kind_q;
	rgb_t rgb_q;
	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic signed [NRM_W-1:0] nrm [LANES];

	// whole pipeline moves unless the output register holds an untaken result
	assign en       = !m_valid_q || out_ready;
	assign item_pop = en && item_valid;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPOS; i++) vld_s[i] <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= item_valid;
			for (int i = 1; i < NPOS; i++) vld_s[i] <= vld_s[i-1];
			m_valid_q <= vld_s[NPOS-1];
		end
	end

	// sideband chain and front stages: load, square, sum
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= '{height: item.height, kind: item.kind,
				neg_x: item.neg_x, neg_y: item.neg_y};
			for (int i = 1; i < NPOS; i++) side_s[i] <= side_s[i-1];
			mx_s1     <= item.mag_x;
			my_s1     <= item.mag_y;
			sqx_s2    <= SQ_W'(mx_s1 * mx_s1);
			sqy_s2    <= SQ_W'(my_s1 * my_s1);
			sum_s3    <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(Z_SQ);
			csq_s3[0] <= SUM_W'(sqx_s2);
			csq_s3[1] <= SUM_W'(sqy_s2);
			csq_s3[2] <= SUM_W'(Z_SQ);
		end
	end

	// restoring division c^2 * 2^30 / S, one quotient bit per stage
	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [SUM_W-1:0] sum_in;
		logic [SUM_W:0]   t_in   [LANES];
		logic [QUO_W-1:0] quo_in [LANES];
		logic [LANES-1:0] qb;
		logic [SUM_W-1:0] rem_nx [LANES];

		if (k == 0) begin : g_first
			assign sum_in = sum_s3;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign t_in[l]   = {1'b0, csq_s3[l]};
				assign quo_in[l] = '0;
			end
		end else begin : g_next
			assign sum_in = dsum_s[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign t_in[l]   = {drem_s[l][k-1], 1'b0};
				assign quo_in[l] = dquo_s[l][k-1];
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				qb[l]     = (t_in[l] >= {1'b0, sum_in});
				rem_nx[l] = qb[l] ? SUM_W'(t_in[l] - {1'b0, sum_in}) : SUM_W'(t_in[l]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dsum_s[k] <= sum_in;
				for (int l = 0; l < LANES; l++) begin
					drem_s[l][k] <= rem_nx[l];
					dquo_s[l][k] <= {quo_in[l][QUO_W-2:0], qb[l]};
				end
			end
		end
	end

	// digit-by-digit integer square root, one root bit per stage
	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		logic [RAD_W-1:0]  rad_in  [LANES];
		logic [SREM_W-1:0] rem_in  [LANES];
		logic [ROOT_W-1:0] root_in [LANES];
		logic [SREM_W+1:0] t       [LANES];
		logic [SREM_W+1:0] trial   [LANES];
		logic [LANES-1:0]  ge;

		if (j == 0) begin : g_first
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rad_in[l]  = {1'b0, dquo_s[l][DIV_N-1]};
				assign rem_in[l]  = '0;
				assign root_in[l] = '0;
			end
		end else begin : g_next
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rad_in[l]  = rad_s[l][j-1];
				assign rem_in[l]  = srem_s[l][j-1];
				assign root_in[l] = root_s[l][j-1];
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				t[l]     = {rem_in[l], rad_in[l][RAD_W-1:RAD_W-2]};
				trial[l] = {1'b0, root_in[l], 2'b01};
				ge[l]    = (t[l] >= trial[l]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rad_s[l][j]  <= {rad_in[l][RAD_W-3:0], 2'b00};
					srem_s[l][j] <= ge[l] ? SREM_W'(t[l] - trial[l]) : SREM_W'(t[l]);
					root_s[l][j] <= {root_in[l][ROOT_W-2:0], ge[l]};
				end
			end
		end
	end

	// round the root to half, apply the sign
	always_comb begin
		logic [ROOT_W:0] half;
		logic neg;
		for (int l = 0; l < LANES; l++) begin
			half = ({1'b0, root_s[l][SQ_N-1]} + 1'b1) >> 1;
			neg  = (l == 0) ? side_s[NPOS-1].neg_x :
				(l == 1) ? side_s[NPOS-1].neg_y : 1'b0;
			nrm[l] = neg ? -$signed(NRM_W'(half)) : $signed(NRM_W'(half));
		end
	end

	// output register; water takes the flat normal
	always_ff @(posedge clk) begin
		if (en) begin
			height_q <= side_s[NPOS-1].height;
			kind_q   <= side_s[NPOS-1].kind;
			rgb_q    <= terrain_color(side_s[NPOS-1].kind);
			if (side_s[NPOS-1].kind == TER_WATER) begin
				nx_q <= '0;
				ny_q <= '0;
				nz_q <= Q_ONE;
			end else begin
				nx_q <= nrm[0];
				ny_q <= nrm[1];
				nz_q <= nrm[2];
			end
		end
	end

	assign out_valid = m_valid_q;
	assign out_data  = {nz_q, ny_q, nx_q, rgb_q.blue, rgb_q.green, rgb_q.red, height_q};

	a_water_flat: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && kind_q == TER_WATER |-> nx_q == '0 && ny_q == '0 && nz_q == Q_ONE)
		else $error("water result without flat normal");

	a_z_positive: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> nz_q > 0 && nz_q <= Q_ONE)
		else $error("normal z out of range");

	a_xy_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> nx_q >= -Q_ONE && nx_q <= Q_ONE && ny_q >= -Q_ONE && ny_q <= Q_ONE)
		else $error("normal x or y exceeds unit length");

endmodule

### rtl/heightmap_normal_and_color.sv
// Terrain shading: height sample plus four neighbors in, color and unit normal out.
// Input stream (s_*): one transaction per pixel, five 8-bit heights in s_tdata.
// Output stream (m_*): one transaction per pixel, same order as the input.
// Configuration: cfg_we writes cfg_data into level register cfg_idx
//   (0 water, 1 sand, 2 snow); other indexes are ignored. Write only while idle.
// Pipeline: three prep stages (load, squares, sum), 31 division stages (one
//   quotient bit each) and 16 square-root stages (one root bit each) run in
//   lock step for the three components, then the output register.
// Throughput: one pixel per cycle, set by the fully pipelined divide and root,
//   as long as m_tready does not hold the back pipeline.
// A classifier in front feeds a small queue (FIFO_DEPTH entries); s_tready
//   drops only when the queue is full.
// When m_tready is low the whole back pipeline holds and the queue fills.
// Reset: levels return to 120/125/200, the queue and pipeline empty.
module heightmap_normal_and_color import hnc_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// height_center, height_left, height_right, height_up, height_down
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// height_out, red, green, blue, normal_x, normal_y, normal_z
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	vec_item_t front_item, queue_item;
	logic q_full, q_valid, q_pop;

	hnc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_data  (s_tdata),
		.item     (front_item)
	);

	hnc_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH ($bits(vec_item_t))
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.wdata     (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (queue_item),
		.not_empty (q_valid)
	);

	assign s_tready = !q_full;

	hnc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (queue_item),
		.item_pop   (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

### tb/sv/heightmap_normal_and_color_tb.sv
`timescale 1ns / 1ps

module heightmap_normal_and_color_tb;
	import hnc_pkg::*;

	typedef struct packed {
		logic [15:0] nz;
		logic [15:0] ny;
		logic [15:0] nx;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  height;
	} shade_t;

	typedef struct {
		logic [7:0] hc, hl, hr, hu, hd;
		bit         typed;
		shade_t     want;
	} pixel_row_t;

	localparam int LATENCY   = 51;
	localparam int IDLE_LIMIT = 5000;
	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]   cfg_data;

	logic [7:0] lvl_water, lvl_sand, lvl_snow;
	shade_t     shade_q[$];
	int         errors;
	int         idle_cycles;
	bit         long_hold;

	heightmap_normal_and_color u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// rounded c * 2^14 / sqrt(s), ties away from zero
	function automatic logic [15:0] q14(longint c, longint s);
		longint m, rhs, lo, hi, mid, t;
		m = (c < 0) ? -c : c;
		rhs = (m * m) << 30;
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			t = 2 * mid - 1;
			if (t * t * s <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return (c < 0) ? 16'(-lo) : 16'(lo);
	endfunction

	function automatic shade_t shade_pixel(logic [7:0] hc, hl, hr, hu, hd);
		shade_t o;
		longint p, q, vx, vy, s;
		p = longint'(hl) - longint'(hr);
		q = longint'(hu) - longint'(hd);
		vx = q - p;
		vy = -(p + q);
		s = vx * vx + vy * vy + 16;
		o.height = hc;
		{o.red, o.green, o.blue} = {8'd0, 8'd154, 8'd22};
		if (hc <= lvl_sand) {o.red, o.green, o.blue} = {8'd248, 8'd214, 8'd114};
		if (hc >= lvl_snow) {o.red, o.green, o.blue} = {8'd255, 8'd250, 8'd250};
		if (hc <= lvl_water) begin
			{o.red, o.green, o.blue} = {8'd0, 8'd84, 8'd148};
			o.nx = 16'd0;
			o.ny = 16'd0;
			o.nz = 16'd16384;
		end else begin
			o.nx = q14(vx, s);
			o.ny = q14(vy, s);
			o.nz = q14(4, s);
		end
		return o;
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		shade_t got, exp_s;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (shade_q.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					errors++;
				end else begin
					exp_s = shade_q.pop_front();
					if (got.height !== exp_s.height) begin
						$error("height_out exp %0d got %0d", exp_s.height, got.height); errors++; end
					if (got.red !== exp_s.red) begin
						$error("red exp %0d got %0d", exp_s.red, got.red); errors++; end
					if (got.green !== exp_s.green) begin
						$error("green exp %0d got %0d", exp_s.green, got.green); errors++; end
					if (got.blue !== exp_s.blue) begin
						$error("blue exp %0d got %0d", exp_s.blue, got.blue); errors++; end
					if (got.nx !== exp_s.nx) begin
						$error("normal_x exp %0d got %0d", $signed(exp_s.nx), $signed(got.nx));
						errors++; end
					if (got.ny !== exp_s.ny) begin
						$error("normal_y exp %0d got %0d", $signed(exp_s.ny), $signed(got.ny));
						errors++; end
					if (got.nz !== exp_s.nz) begin
						$error("normal_z exp %0d got %0d", $signed(exp_s.nz), $signed(got.nz));
						errors++; end
				end
			end
			if (long_hold) m_tready <= 1'b0;
			else m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WATER: lvl_water = val;
			REG_SAND:  lvl_sand = val;
			REG_SNOW:  lvl_snow = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (shade_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// offer one pixel and hold it until the transaction completes
	task automatic send_pixel(logic [7:0] hc, hl, hr, hu, hd);
		s_tvalid <= 1'b1;
		s_tdata <= {hd, hu, hr, hl, hc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		shade_q.insert(shade_q.size(), shade_pixel(hc, hl, hr, hu, hd));
	endtask

	task automatic gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic random_burst(int n);
		int left, len;
		logic [7:0] hc, hl, hr, hu, hd;
		left = n;
		while (left > 0) begin
			len = $urandom_range(1, 24);
			repeat (len) begin
				if (left > 0) begin
					hc = $urandom;
					hl = $urandom; hr = $urandom; hu = $urandom; hd = $urandom;
					if ($urandom_range(0, 3) == 0) begin
						hr = hl + 8'($urandom_range(0, 4));
						hd = hu - 8'($urandom_range(0, 4));
					end
					send_pixel(hc, hl, hr, hu, hd);
					left--;
				end
			end
			if ($urandom_range(0, 2) != 0) gap();
		end
		s_tvalid <= 1'b0;
	endtask

	pixel_row_t rows[$];
	pixel_row_t r;
	shade_t     typed;

	initial begin
		errors = 0;
		idle_cycles = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_WATER;
		cfg_data = '0;
		lvl_water = WATER_RST;
		lvl_sand = SAND_RST;
		lvl_snow = SNOW_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed rows are water cases, the rest use the predictor
		r.typed = 1'b1;
		r.want = '{nz: 16'd16384, ny: 16'd0, nx: 16'd0, blue: 8'd148, green: 8'd84,
			red: 8'd0, height: 8'd0};
		r.hc = 0; r.hl = 255; r.hr = 0; r.hu = 0; r.hd = 255; rows.insert(rows.size(), r);
		r.want.height = 120;
		r.hc = 120; r.hl = 0; r.hr = 255; r.hu = 255; r.hd = 0; rows.insert(rows.size(), r);
		r.typed = 1'b0;
		r.hc = 121; r.hl = 0; r.hr = 0; r.hu = 0; r.hd = 0; rows.insert(rows.size(), r);
		r.hc = 125; r.hl = 255; r.hr = 0; r.hu = 0; r.hd = 255; rows.insert(rows.size(), r);
		r.hc = 126; r.hl = 0; r.hr = 255; r.hu = 255; r.hd = 0; rows.insert(rows.size(), r);
		r.hc = 199; r.hl = 255; r.hr = 0; r.hu = 255; r.hd = 0; rows.insert(rows.size(), r);
		r.hc = 200; r.hl = 0; r.hr = 255; r.hu = 0; r.hd = 255; rows.insert(rows.size(), r);
		r.hc = 255; r.hl = 255; r.hr = 255; r.hu = 255; r.hd = 255;
		rows.insert(rows.size(), r);
		r.hc = 170; r.hl = 1; r.hr = 0; r.hu = 0; r.hd = 1; rows.insert(rows.size(), r);
		r.hc = 170; r.hl = 170; r.hr = 85; r.hu = 85; r.hd = 170; rows.insert(rows.size(), r);
		r.hc = 230; r.hl = 128; r.hr = 127; r.hu = 127; r.hd = 128;
		rows.insert(rows.size(), r);
		foreach (rows[i]) begin
			typed = shade_pixel(rows[i].hc, rows[i].hl, rows[i].hr, rows[i].hu, rows[i].hd);
			if (rows[i].typed && typed !== rows[i].want) begin
				$error("typed row %0d: exp %h predicted %h", i, rows[i].want, typed);
				errors++;
			end
			send_pixel(rows[i].hc, rows[i].hl, rows[i].hr, rows[i].hu, rows[i].hd);
			if (i % 3 == 2) gap();
		end
		s_tvalid <= 1'b0;
		wait_drained();

		// snow below sand, water over all
		cfg_write(REG_WATER, 8'd50);
		cfg_write(REG_SAND, 8'd200);
		cfg_write(REG_SNOW, 8'd100);
		cfg_write(REG_UNUSED, 8'd7);
		random_burst(250);
		wait_drained();

		// extremes: everything water
		cfg_write(REG_WATER, 8'd255);
		cfg_write(REG_SAND, 8'd0);
		cfg_write(REG_SNOW, 8'd255);
		random_burst(60);
		wait_drained();

		// water only at height 0, snow only at top, long receiver hold while sending
		cfg_write(REG_WATER, 8'd0);
		cfg_write(REG_SAND, 8'd0);
		cfg_write(REG_SNOW, 8'd255);
		fork
			begin
				long_hold = 1'b1;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end
			random_burst(300);
		join
		wait_drained();

		// back to defaults, then random levels
		cfg_write(REG_WATER, WATER_RST);
		cfg_write(REG_SAND, SAND_RST);
		cfg_write(REG_SNOW, SNOW_RST);
		random_burst(200);
		wait_drained();
		cfg_write(REG_WATER, 8'($urandom));
		cfg_write(REG_SAND, 8'($urandom));
		cfg_write(REG_SNOW, 8'($urandom));
		random_burst(230);

		while (shade_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && shade_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
rtl/hnc_pkg.sv
rtl/hnc_front.sv
rtl/hnc_fifo.sv
rtl/hnc_back.sv
rtl/heightmap_normal_and_color.sv
tb/sv/heightmap_normal_and_color_tb.sv
